### hdl/integer_to_ascii_formatter_defines.svh
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define I2A_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2a: same-cycle check failed");
// Next-cycle implication.
`define I2A_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2a: next-cycle check failed");
`else
`define I2A_ASSERT_IMP(label, clk, rstn, ante, cons)
`define I2A_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### hdl/i2a_pkg.sv
package i2a_pkg;

    // Conversion kinds
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;
    localparam logic [2:0] OP_CHAR = 3'd5;

    localparam int POINTER_BITS = 64;
    localparam logic [63:0] PTR_MASK = 64'((65'd1 << POINTER_BITS) - 65'd1);

    localparam int MAX_CHARS = 18;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int NIL_LEN   = 5;
    localparam int NIL_W     = $clog2(NIL_LEN);

    // x / 10 == (x * 0xCCCCCCCD) >> 35 for any 32-bit x
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_X      = 8'h78;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // "(nil)"
    localparam logic [7:0] NIL_TEXT [NIL_LEN] = '{8'h28, 8'h6E, 8'h69, 8'h6C, 8'h29};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL,
        ST_DEC,
        ST_HEX,
        ST_SIGN,
        ST_PX,
        ST_P0,
        ST_NIL,
        ST_CHAR,
        ST_EMIT
    } i2a_state_t;

    // Source of the character pushed into the text buffer
    typedef enum logic [2:0] {
        PS_DEC,
        PS_HEX,
        PS_MINUS,
        PS_X,
        PS_ZERO,
        PS_NIL,
        PS_CHAR
    } push_sel_t;

    typedef struct packed {
        logic      load;
        logic      mul;
        logic      push;
        push_sel_t sel;
        logic      pop;
    } i2a_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       neg;
        logic       work_zero;
        logic       dec_last;
        logic       hex_last;
        logic       nil_last;
        logic       emit_last;
    } i2a_stat_t;

endpackage

### hdl/i2a_dp.sv
`include "integer_to_ascii_formatter_defines.svh"

module i2a_dp import i2a_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [2:0]  in_op,
    input  logic [63:0] in_value,
    input  i2a_cmd_t    cmd,
    output i2a_stat_t   stat,
    output logic [7:0]  out_char,
    output logic        out_last
);

    logic [2:0]             op_reg;
    logic                   neg_reg;
    logic [63:0]            work_reg, work_next;
    logic [63:0]            prod_reg;
    logic [NIL_W-1:0]       nil_idx_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [7:0]             chars_reg [MAX_CHARS];

    logic [31:0]            low;
    logic                   in_neg;
    logic [31:0]            mag;
    logic [63-DEC_SHIFT:0]  quo;
    logic [31:0]            quo10;
    logic [31:0]            rem_full;
    logic [7:0]             case_or;
    logic [7:0]             push_char;

    assign low    = in_value[31:0];
    assign in_neg = (in_op == OP_SDEC) && low[31];
    assign mag    = in_neg ? (32'd0 - low) : low;

    // quotient and remainder of the current decimal step
    assign quo      = prod_reg[63:DEC_SHIFT];
    assign quo10    = 32'({quo, 3'b000}) + 32'({quo, 1'b0});
    assign rem_full = work_reg[31:0] - quo10;

    assign case_or = ((op_reg == OP_HEXL) || (op_reg == OP_PTR)) ? CASE_BIT : 8'h00;

    always_comb begin
        case (cmd.sel)
            PS_DEC:   push_char = CH_ZERO | {4'd0, rem_full[3:0]};
            PS_HEX:   push_char = HEX_DIGITS[work_reg[3:0]] | case_or;
            PS_MINUS: push_char = CH_MINUS;
            PS_X:     push_char = CH_X;
            PS_ZERO:  push_char = CH_ZERO;
            PS_NIL:   push_char = NIL_TEXT[nil_idx_reg];
            PS_CHAR:  push_char = work_reg[7:0];
            default:  push_char = CH_ZERO;
        endcase
    end

    always_comb begin
        work_next = work_reg;
        if (cmd.load) begin
            work_next = (in_op == OP_PTR) ? (in_value & PTR_MASK) : {32'd0, mag};
        end else if (cmd.push && cmd.sel == PS_DEC) begin
            work_next = 64'(quo);
        end else if (cmd.push && cmd.sel == PS_HEX) begin
            work_next = work_reg >> 4;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.load) begin
            count_next = '0;
        end else if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (cmd.load) begin
            op_reg      <= in_op;
            neg_reg     <= in_neg;
            nil_idx_reg <= NIL_W'(NIL_LEN - 1);
        end
        if (cmd.mul) begin
            prod_reg <= work_reg[31:0] * DEC_RECIP;
        end
        if (cmd.push && cmd.sel == PS_NIL) begin
            nil_idx_reg <= nil_idx_reg - NIL_W'(1);
        end
        // text is built last character first; slot 0 ends up as the first
        if (cmd.push) begin
            chars_reg[0] <= push_char;
            for (int i = 1; i < MAX_CHARS; i++) begin
                chars_reg[i] <= chars_reg[i-1];
            end
        end else if (cmd.pop) begin
            for (int i = 0; i < MAX_CHARS - 1; i++) begin
                chars_reg[i] <= chars_reg[i+1];
            end
        end
    end

    assign stat.op        = op_reg;
    assign stat.neg       = neg_reg;
    assign stat.work_zero = (work_reg == 64'd0);
    assign stat.dec_last  = (quo == '0);
    assign stat.hex_last  = (work_reg[63:4] == 60'd0);
    assign stat.nil_last  = (nil_idx_reg == '0);
    assign stat.emit_last = (count_reg == CNT_W'(1));

    assign out_char = chars_reg[0];
    assign out_last = stat.emit_last;

    `I2A_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_CHARS))
    `I2A_ASSERT_NXT(a_push_grows, aclk, aresetn, cmd.push && !cmd.load,
                    count_reg == $past(count_reg) + CNT_W'(1))
    `I2A_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, cmd.pop, count_reg != '0)

endmodule

### hdl/i2a_ctrl.sv
`include "integer_to_ascii_formatter_defines.svh"

module i2a_ctrl import i2a_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      out_ready,
    input  i2a_stat_t stat,
    output i2a_cmd_t  cmd,
    output logic      in_ready,
    output logic      out_valid
);

    i2a_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.mul    = 1'b0;
        cmd.push   = 1'b0;
        cmd.sel    = PS_DEC;
        cmd.pop    = 1'b0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.op)
                    OP_SDEC, OP_UDEC: state_next = ST_MUL;
                    OP_HEXL, OP_HEXU: state_next = ST_HEX;
                    OP_PTR:           state_next = stat.work_zero ? ST_NIL : ST_HEX;
                    OP_CHAR:          state_next = ST_CHAR;
                    default:          state_next = ST_IDLE;   // unused kind: dropped
                endcase
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                cmd.push = 1'b1;
                cmd.sel  = PS_DEC;
                if (stat.dec_last) begin
                    state_next = stat.neg ? ST_SIGN : ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_HEX: begin
                cmd.push = 1'b1;
                cmd.sel  = PS_HEX;
                if (stat.hex_last) begin
                    state_next = (stat.op == OP_PTR) ? ST_PX : ST_EMIT;
                end
            end
            ST_SIGN: begin
                cmd.push   = 1'b1;
                cmd.sel    = PS_MINUS;
                state_next = ST_EMIT;
            end
            ST_PX: begin
                cmd.push   = 1'b1;
                cmd.sel    = PS_X;
                state_next = ST_P0;
            end
            ST_P0: begin
                cmd.push   = 1'b1;
                cmd.sel    = PS_ZERO;
                state_next = ST_EMIT;
            end
            ST_NIL: begin
                cmd.push = 1'b1;
                cmd.sel  = PS_NIL;
                if (stat.nil_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_CHAR: begin
                cmd.push   = 1'b1;
                cmd.sel    = PS_CHAR;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.pop = 1'b1;
                    if (stat.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `I2A_ASSERT_IMP(a_no_overlap, aclk, aresetn, in_ready, !out_valid)
    `I2A_ASSERT_NXT(a_accept_dispatch, aclk, aresetn, in_valid && in_ready,
                    state_reg == ST_DISPATCH)
    `I2A_ASSERT_NXT(a_last_to_idle, aclk, aresetn,
                    out_valid && out_ready && stat.emit_last, in_ready)

endmodule

### hdl/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter, printf style.
// Slave channel: one item carries a conversion kind in s_tuser (0 signed dec,
// 1 unsigned dec, 2 hex lower, 3 hex upper, 4 pointer, 5 char) and the 64-bit
// argument in s_tdata. Kinds 6 and 7 are accepted and produce nothing.
// Master channel: one ASCII character per item in m_tdata, most significant
// first; m_tlast marks the final character of a conversion (1 to 18 chars).
// Timing: the block works on one item at a time. After accept, a dispatch
// state, then the text is built into an 18-slot shift buffer: each decimal
// digit takes a registered reciprocal multiply, then the remainder; each hex
// digit, sign, prefix, "(nil)" or char character is pushed directly. The text
// then drains one character per cycle while m_tready is high. The decimal
// digit loop through the multiplier sets the worst case for the decimal kinds.
// s_tready is high only when idle, so no new item enters while text drains.
// Stalls: m_tdata/m_tlast hold while m_tvalid is high and m_tready is low.
// Reset (aresetn low, synchronous) returns to idle and empties the buffer.
module integer_to_ascii_formatter import i2a_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] value
    input  logic [2:0]  s_tuser,    // [2:0] op
    // character stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] character
    output logic        m_tlast     // last
);

    i2a_cmd_t  cmd;
    i2a_stat_t stat;

    // sequencer: walks digits, prefixes and drain
    i2a_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    // datapath: working value, divide-by-ten, text buffer
    i2a_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_op    (s_tuser),
        .in_value (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_char (m_tdata),
        .out_last (m_tlast)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import i2a_pkg::*;

    // Kinds 6 and 7 are accepted by the block and produce no text
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam logic [7:0] LOWER_CASE  = 8'h20;
    localparam int         RESET_CYCLES = 7;
    localparam int         TAIL_CYCLES  = 60;    // > worst build time of one item
    localparam int         ITEMS_PER_PHASE = 40;
    localparam int         PHASES = 4;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // [63:0] value
    logic [2:0]  s_tuser = '0;     // [2:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] character
    logic        m_tlast;          // last

    // characters still owed by the block, oldest first
    text_char_t  text_expect_q[$];
    int          mismatch_count = 0;
    int          sender_idle_pct = 0;
    int          rcv_stall_pct = 0;

    // idle / stall percentages per random phase: none, sender, receiver, both
    int idle_by_phase  [PHASES] = '{0, 58, 0, 21};
    int stall_by_phase [PHASES] = '{0, 0, 58, 21};

    logic [2:0] conv_kinds [6] = '{OP_SDEC, OP_UDEC, OP_HEXL, OP_HEXU, OP_PTR, OP_CHAR};

    // low words that sit on a digit-count or sign boundary
    logic [31:0] corner_low [12] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0009, 32'h0000_000A,
        32'h0000_000F, 32'h0000_0010, 32'h3B9A_C9FF, 32'h3B9A_CA00,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF
    };

    // Directed table. Text is typed where it is obvious; an empty text means
    // the row is checked against the predictor instead.
    localparam int DIR_ROWS = 25;
    logic [2:0] dir_op [DIR_ROWS] = '{
        OP_SDEC, OP_SDEC, OP_SDEC, OP_SDEC, OP_SDEC, OP_SDEC,
        OP_UDEC, OP_UDEC, OP_UDEC, OP_UDEC,
        OP_HEXL, OP_HEXL, OP_HEXU, OP_HEXL, OP_HEXU,
        OP_PTR,  OP_PTR,  OP_PTR,  OP_PTR,  OP_PTR,
        OP_CHAR, OP_CHAR, OP_CHAR,
        OP_UNUSED_6, OP_UNUSED_7
    };
    logic [63:0] dir_arg [DIR_ROWS] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_8000_0000,
        64'h0000_0000_7FFF_FFFF, 64'h0000_0000_FFFF_FFFF,
        64'hDEAD_BEEF_0000_0005, 64'h0000_0000_FFFF_FFF6,
        64'h0000_0000_0000_0000, 64'h0000_0000_FFFF_FFFF,
        64'hFFFF_FFFF_0000_000A, 64'h0000_0000_3B9A_CA00,
        64'h0000_0000_0000_0000, 64'h0000_0000_FFFF_FFFF,
        64'h0000_0000_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0,
        64'h1234_5678_9ABC_DEF0,
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0000_0001_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_00FF,
        64'hFFFF_FFFF_FFFF_FF41,
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF
    };
    string dir_text [DIR_ROWS] = '{
        "0", "-2147483648", "2147483647", "-1", "5", "-10",
        "0", "4294967295", "10", "1000000000",
        "0", "ffffffff", "FFFFFFFF", "9abcdef0", "9ABCDEF0",
        "(nil)", "0xffffffffffffffff", "0x1", "0x8000000000000000", "0x100000000",
        "", "", "A",
        "", ""
    };

    integer_to_ascii_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t ns: %s mismatch, expected %0h got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic [7:0] case_or);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return (8'h41 + 8'(nib) - 8'd10) | case_or;
    endfunction

    // Text the block should produce for one conversion; queued as expectations.
    function automatic void format_expected(input logic [2:0] op, input logic [63:0] arg);
        logic [7:0]  txt[$];
        logic [31:0] low;
        logic [31:0] mag;
        logic [63:0] work;
        logic [63:0] ptr_mask;
        logic [7:0]  case_or;
        string       nil_txt;
        low = arg[31:0];
        ptr_mask = (POINTER_BITS >= 64) ? '1 : ((64'd1 << POINTER_BITS) - 64'd1);
        nil_txt = "(nil)";
        case (op)
            OP_SDEC, OP_UDEC: begin
                mag = (op == OP_SDEC && low[31]) ? (32'd0 - low) : low;
                do begin
                    txt.push_front(8'h30 + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 0);
                if (op == OP_SDEC && low[31])
                    txt.push_front("-");
            end
            OP_HEXL, OP_HEXU, OP_PTR: begin
                work = (op == OP_PTR) ? (arg & ptr_mask) : {32'd0, low};
                case_or = (op == OP_HEXU) ? 8'h00 : LOWER_CASE;
                if (op == OP_PTR && work == 0) begin
                    // null pointer: no prefix, fixed text
                    for (int k = 0; k < nil_txt.len(); k++)
                        txt.push_back(nil_txt[k]);
                end else begin
                    do begin
                        txt.push_front(hex_char(work[3:0], case_or));
                        work = work >> 4;
                    end while (work != 0);
                    if (op == OP_PTR) begin
                        txt.push_front("x");
                        txt.push_front("0");
                    end
                end
            end
            OP_CHAR: txt.push_back(arg[7:0]);   // raw byte, zero included
            default: ;                          // unused kinds: no text
        endcase
        for (int i = 0; i < txt.size(); i++)
            text_expect_q.push_back('{ch: txt[i], last: (i == txt.size() - 1)});
    endfunction

    function automatic logic [63:0] pick_argument();
        logic [63:0] raw;
        logic [31:0] upper;
        raw = {$urandom, $urandom};
        upper = $urandom_range(0, 1) ? raw[63:32] : 32'd0;
        case ($urandom_range(0, 3))
            0:       return raw;
            1:       return {upper, 32'($urandom_range(0, 20))};
            2:       return {upper, corner_low[$urandom_range(0, 11)]};
            default: return raw >> $urandom_range(0, 63);   // vary the digit count
        endcase
    endfunction

    // One item on the input channel. Typed text, if any, replaces prediction.
    task automatic send_conversion(input logic [2:0] op, input logic [63:0] arg,
                                   input string typed);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= arg;
        do @(posedge aclk); while (!s_tready);
        if (typed.len() != 0) begin
            for (int i = 0; i < typed.len(); i++)
                text_expect_q.push_back('{ch: typed[i], last: (i == typed.len() - 1)});
        end else begin
            format_expected(op, arg);
        end
    endtask

    // Hold the input channel off until every owed character has come out.
    task automatic wait_text_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (text_expect_q.size() != 0);
    endtask

    // Receiver: random back-pressure at the current phase's rate
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // Output checker: every accepted character against the oldest expectation
    always @(posedge aclk) begin : check_text
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (text_expect_q.size() == 0) begin
                report_mismatch("unexpected character", '0, {m_tlast, m_tdata});
            end else begin
                want = text_expect_q.pop_front();
                if (m_tdata !== want.ch)
                    report_mismatch("character", want.ch, m_tdata);
                if (m_tlast !== want.last)
                    report_mismatch("last flag", want.last, m_tlast);
            end
        end
    end

    initial begin : stimulus
        int          sent;
        logic [2:0]  op;
        logic [63:0] arg;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, no idling
        for (int r = 0; r < DIR_ROWS; r++)
            send_conversion(dir_op[r], dir_arg[r], dir_text[r]);
        wait_text_drained();

        // random rows; between phases the input side waits for all text
        for (int ph = 0; ph < PHASES; ph++) begin
            sender_idle_pct = idle_by_phase[ph];
            rcv_stall_pct   = stall_by_phase[ph];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                arg = pick_argument();
                case ($urandom_range(0, 19))
                    18:      op = OP_UNUSED_6;
                    19:      op = OP_UNUSED_7;
                    default: begin
                        op = conv_kinds[$urandom_range(0, 5)];
                        sent++;          // ignored kinds do not count
                    end
                endcase
                send_conversion(op, arg, "");
            end
            wait_text_drained();
        end

        // catch any stray character after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (text_expect_q.size() != 0)
            report_mismatch("missing characters", text_expect_q.size(), '0);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (~200 items of up to 18
    // characters each, under random stalls)
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/i2a_pkg.sv
hdl/i2a_dp.sv
hdl/i2a_ctrl.sv
hdl/integer_to_ascii_formatter.sv
tb/tb.sv
